FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted (active low).
`define TGC_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked check that also runs through reset.
`define TGC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/tgc_pkg.sv
package tgc_pkg;

  localparam int unsigned POS_W  = 9;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned THR_W  = 9;
  localparam int unsigned GEST_W = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // in_tdata: pos_x, pos_y, now_ms (lowest bit up), padded to 56 bits
  localparam int unsigned IN_TDATA_W  = 56;
  // out_tdata: gesture, tap_x, tap_y (lowest bit up), padded to 24 bits
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_PAY_W   = GEST_W + 2 * POS_W;

  typedef enum logic [GEST_W-1:0] {
    GEST_NONE  = 3'd0,
    GEST_LEFT  = 3'd1,
    GEST_RIGHT = 3'd2,
    GEST_UP    = 3'd3,
    GEST_DOWN  = 3'd4,
    GEST_TAP   = 3'd5,
    GEST_LONG  = 3'd6
  } gesture_t;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SWIPE_MAX   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_MAX    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HORIZ_THR   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_VERT_THR    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TAP_RADIUS  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_TAP_DEBOUNCE = 3'd5;

  // Register reset values
  localparam logic [MS_W-1:0]  RST_SWIPE_MAX    = 16'd500;
  localparam logic [MS_W-1:0]  RST_LONG_MAX     = 16'd2000;
  localparam logic [THR_W-1:0] RST_HORIZ_THR    = 9'd30;
  localparam logic [THR_W-1:0] RST_VERT_THR     = 9'd50;
  localparam logic [THR_W-1:0] RST_TAP_RADIUS   = 9'd50;
  localparam logic [MS_W-1:0]  RST_TAP_DEBOUNCE = 16'd100;

  typedef struct packed {
    logic [MS_W-1:0]  swipe_max_ms;
    logic [MS_W-1:0]  long_press_max_ms;
    logic [THR_W-1:0] horiz_threshold;
    logic [THR_W-1:0] vert_threshold;
    logic [THR_W-1:0] tap_radius;
    logic [MS_W-1:0]  tap_debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic              touch_present;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic              active;
    logic [POS_W-1:0]  start_px;
    logic [POS_W-1:0]  start_py;
    logic [TIME_W-1:0] start_ms;
    logic [POS_W-1:0]  end_px;
    logic [POS_W-1:0]  end_py;
  } stroke_t;

  typedef struct packed {
    gesture_t         gesture;
    logic [POS_W-1:0] tap_x;
    logic [POS_W-1:0] tap_y;
  } result_t;

endpackage

FILE: rtl/core/tgc_classify.sv
module tgc_classify
  import tgc_pkg::*;
(
  input  sample_t           smp,
  input  stroke_t           stk,
  input  logic [TIME_W-1:0] last_tap_ms,
  input  cfg_t              cfg,
  output result_t           res,
  output logic              tap_hit
);

  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] since_tap;
  logic [POS_W-1:0]  ax;
  logic [POS_W-1:0]  ay;
  logic              small_move;
  logic              short_win;
  logic              long_win;

  always_comb begin
    dur       = smp.now_ms - stk.start_ms;
    since_tap = smp.now_ms - last_tap_ms;
    ax = (stk.end_px >= stk.start_px) ? stk.end_px - stk.start_px
                                      : stk.start_px - stk.end_px;
    ay = (stk.end_py >= stk.start_py) ? stk.end_py - stk.start_py
                                      : stk.start_py - stk.end_py;
    small_move = (ax < cfg.tap_radius) && (ay < cfg.tap_radius);
    short_win  = dur < {{(TIME_W-MS_W){1'b0}}, cfg.swipe_max_ms};
    long_win   = (dur > {{(TIME_W-MS_W){1'b0}}, cfg.swipe_max_ms}) &&
                 (dur < {{(TIME_W-MS_W){1'b0}}, cfg.long_press_max_ms});
  end

  always_comb begin
    res.gesture = GEST_NONE;
    res.tap_x   = '0;
    res.tap_y   = '0;
    tap_hit     = 1'b0;
    // only a release that closes an open stroke is classified
    if (!smp.touch_present && stk.active) begin
      if (short_win) begin
        if ((ax > ay) && (ax > cfg.horiz_threshold)) begin
          res.gesture = (stk.end_px < stk.start_px) ? GEST_LEFT : GEST_RIGHT;
        end else if ((ay > ax) && (ay > cfg.vert_threshold)) begin
          res.gesture = (stk.end_py < stk.start_py) ? GEST_UP : GEST_DOWN;
        end else if (small_move &&
                     (since_tap >= {{(TIME_W-MS_W){1'b0}}, cfg.tap_debounce_ms})) begin
          res.gesture = GEST_TAP;
          res.tap_x   = stk.end_px;
          res.tap_y   = stk.end_py;
          tap_hit     = 1'b1;
        end
      end else if (long_win && small_move) begin
        res.gesture = GEST_LONG;
      end
    end
  end

endmodule

FILE: rtl/core/tgc_track.sv
module tgc_track
  import tgc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              smp_acc,
  input  sample_t           smp,
  input  logic              tap_hit,
  output stroke_t           stk,
  output logic [TIME_W-1:0] last_tap_ms
);

  stroke_t           stroke_r, stroke_nxt;
  logic [TIME_W-1:0] last_tap_r, last_tap_nxt;

  always_comb begin
    stroke_nxt   = stroke_r;
    last_tap_nxt = last_tap_r;
    if (smp_acc) begin
      if (smp.touch_present) begin
        if (!stroke_r.active) begin
          stroke_nxt.active   = 1'b1;
          stroke_nxt.start_px = smp.pos_x;
          stroke_nxt.start_py = smp.pos_y;
          stroke_nxt.start_ms = smp.now_ms;
        end
        stroke_nxt.end_px = smp.pos_x;
        stroke_nxt.end_py = smp.pos_y;
      end else if (stroke_r.active) begin
        stroke_nxt = '0;
        if (tap_hit) begin
          last_tap_nxt = smp.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stroke_r   <= '0;
      last_tap_r <= '0;
    end else begin
      stroke_r   <= stroke_nxt;
      last_tap_r <= last_tap_nxt;
    end
  end

  assign stk         = stroke_r;
  assign last_tap_ms = last_tap_r;

endmodule

FILE: rtl/core/touch_gesture_classifier.sv
// An accepted input item shows on out_tvalid in the next cycle.
// Throughput: one item per cycle while out_tready is high; the single output
//   register frees in the cycle its item is taken, keeping in_tready high.
// Reset (rst_n low, synchronous): no open stroke, stored points and last tap
//   time cleared, registers back to defaults, output register empty.
module touch_gesture_classifier
  import tgc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input samples
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pos_x, pos_y, now_ms, zero pad
  input  logic [0:0]             in_tuser,   // touch_present
  // gesture results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // gesture, tap_x, tap_y, zero pad
  // register writes
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t              cfg_r;
  sample_t           smp;
  stroke_t           stk;
  logic [TIME_W-1:0] last_tap_ms;
  result_t           res;
  logic              tap_hit;
  logic              in_acc;

  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;

  // Unpack the sample; touch flag rides on tuser
  assign smp.touch_present = in_tuser[0];
  assign smp.pos_x  = in_tdata[POS_W-1:0];
  assign smp.pos_y  = in_tdata[2*POS_W-1:POS_W];
  assign smp.now_ms = in_tdata[2*POS_W+TIME_W-1:2*POS_W];

  // Output register doubles as the skid stage: accept whenever it is empty
  // or being drained this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Register file; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_max_ms      <= RST_SWIPE_MAX;
      cfg_r.long_press_max_ms <= RST_LONG_MAX;
      cfg_r.horiz_threshold   <= RST_HORIZ_THR;
      cfg_r.vert_threshold    <= RST_VERT_THR;
      cfg_r.tap_radius        <= RST_TAP_RADIUS;
      cfg_r.tap_debounce_ms   <= RST_TAP_DEBOUNCE;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SWIPE_MAX:    cfg_r.swipe_max_ms      <= cfg_wdata;
        CFG_LONG_MAX:     cfg_r.long_press_max_ms <= cfg_wdata;
        CFG_HORIZ_THR:    cfg_r.horiz_threshold   <= cfg_wdata[THR_W-1:0];
        CFG_VERT_THR:     cfg_r.vert_threshold    <= cfg_wdata[THR_W-1:0];
        CFG_TAP_RADIUS:   cfg_r.tap_radius        <= cfg_wdata[THR_W-1:0];
        CFG_TAP_DEBOUNCE: cfg_r.tap_debounce_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stroke bookkeeping: start/end points, start time, last tap time
  tgc_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .smp_acc     (in_acc),
    .smp         (smp),
    .tap_hit     (tap_hit),
    .stk         (stk),
    .last_tap_ms (last_tap_ms)
  );

  // Release-time classification against the current stroke state
  tgc_classify u_classify (
    .smp         (smp),
    .stk         (stk),
    .last_tap_ms (last_tap_ms),
    .cfg         (cfg_r),
    .res         (res),
    .tap_hit     (tap_hit)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_PAY_W){1'b0}},
                       out_res_r.tap_y, out_res_r.tap_x, out_res_r.gesture};

endmodule

FILE: rtl/core/tgc_checker.sv
`include "assert_macros.svh"

module tgc_checker
  import tgc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [0:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [GEST_W-1:0] gest;
  assign gest = out_tdata[GEST_W-1:0];

  `TGC_ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> !out_tvalid, "result pending after reset")

  `TGC_ASSERT(a_hold_stalled, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  `TGC_ASSERT(a_touch_gives_none, clk, rst_n, in_tvalid && in_tready && in_tuser[0] |=> out_tvalid && (gest == GEST_NONE), "touched item did not give an empty result")

  `TGC_ASSERT(a_tap_fields_zero, clk, rst_n, out_tvalid && (gest != GEST_TAP) |-> (out_tdata[OUT_TDATA_W-1:GEST_W] == '0), "position on a non-tap result")

  `TGC_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty output")

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (.*);
